[src/websocket_frame_receiver_defines.svh]
// Assertion macros used by the checker file of the frame receiver.
`ifndef WEBSOCKET_FRAME_RECEIVER_DEFINES_SVH
`define WEBSOCKET_FRAME_RECEIVER_DEFINES_SVH

// Same-cycle implication, checked on every clock outside reset.
`define WFR_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("websocket_frame_receiver: check failed");

// Next-cycle implication, checked on every clock outside reset.
`define WFR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("websocket_frame_receiver: check failed");

`endif

[src/wfr_pkg.sv]
`timescale 1ns / 1ps

package wfr_pkg;

	// Default width of the buffer space and stored counters
	localparam int CAPACITY_BITS_DEF = 16;

	// 7-bit length codes that announce an extended length
	localparam logic [6:0] LEN16_CODE = 7'd126;
	localparam logic [6:0] LEN64_CODE = 7'd127;

	// Item kinds on the input side
	localparam logic KIND_START = 1'b0;
	localparam logic KIND_BYTE  = 1'b1;

	// Parser phase, one-hot
	typedef enum logic [7:0] {
		PH_IDLE    = 8'b0000_0001,
		PH_HDR0    = 8'b0000_0010,
		PH_HDR1    = 8'b0000_0100,
		PH_EXT16   = 8'b0000_1000,
		PH_EXT64   = 8'b0001_0000,
		PH_MASK    = 8'b0010_0000,
		PH_PAYLOAD = 8'b0100_0000,
		PH_DONE    = 8'b1000_0000
	} phase_t;

	// One input item as held in the input register
	typedef struct packed {
		logic        kind;
		logic [15:0] capacity;
		logic [7:0]  rx_byte;
	} item_t;

	// One result item
	typedef struct packed {
		logic        byte_valid;
		logic [7:0]  out_byte;
		logic [15:0] out_index;
		logic        message_done;
		logic [15:0] message_length;
		logic [3:0]  frame_opcode;
	} result_t;

endpackage

[src/wfr_parser.sv]
`timescale 1ns / 1ps

// Frame parser state and per-item update. The item at the input register is
// consumed when en is high; res/res_valid describe the result it causes.
module wfr_parser #(
	parameter int CAPACITY_BITS = wfr_pkg::CAPACITY_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  wfr_pkg::item_t   item,
	output logic             res_valid,
	output wfr_pkg::result_t res
);

	localparam int CW = CAPACITY_BITS;

	wfr_pkg::phase_t phase_q, phase_d;
	logic          final_q, final_d;
	logic          mask_q, mask_d;
	logic [2:0]    hbc_q, hbc_d;
	logic [31:0]   fbl_q, fbl_d;
	logic [CW-1:0] space_q, space_d;
	logic [CW-1:0] sc_q, sc_d;
	logic [31:0]   key_q, key_d;
	logic [1:0]    mpos_q, mpos_d;
	logic [3:0]    opc_q, opc_d;

	logic          len_known, pay_begin, frame_end, stored, done;
	logic [7:0]    b;
	logic [6:0]    len7;
	logic [7:0]    val;
	logic [31:0]   key_sh;
	logic [31:0]   cap32;
	logic [31:0]   sc_old32, sc_new32;

	assign b        = item.rx_byte;
	assign len7     = item.rx_byte[6:0];
	assign cap32    = {16'd0, item.capacity};
	assign sc_old32 = 32'(sc_q);
	assign sc_new32 = 32'(sc_d);

	// Key byte for the current position, first key byte first
	assign key_sh = key_q >> {~mpos_q, 3'b000};
	assign val    = mask_q ? (b ^ key_sh[7:0]) : b;

	// Next state
	always_comb begin
		phase_d   = phase_q;
		final_d   = final_q;
		mask_d    = mask_q;
		hbc_d     = hbc_q;
		fbl_d     = fbl_q;
		space_d   = space_q;
		sc_d      = sc_q;
		key_d     = key_q;
		mpos_d    = mpos_q;
		opc_d     = opc_q;
		len_known = 1'b0;
		pay_begin = 1'b0;
		frame_end = 1'b0;
		stored    = 1'b0;
		done      = 1'b0;

		if (item.kind == wfr_pkg::KIND_START) begin
			space_d = cap32[CW-1:0];
			sc_d    = '0;
			final_d = 1'b0;
			mask_d  = 1'b0;
			hbc_d   = '0;
			fbl_d   = '0;
			key_d   = '0;
			mpos_d  = '0;
			phase_d = wfr_pkg::PH_HDR0;
		end else begin
			case (phase_q)
				wfr_pkg::PH_HDR0: begin
					final_d = b[7];
					opc_d   = b[3:0];
					phase_d = wfr_pkg::PH_HDR1;
				end
				wfr_pkg::PH_HDR1: begin
					mask_d = b[7];
					hbc_d  = '0;
					fbl_d  = '0;
					if (len7 == wfr_pkg::LEN16_CODE) begin
						phase_d = wfr_pkg::PH_EXT16;
					end else if (len7 == wfr_pkg::LEN64_CODE) begin
						phase_d = wfr_pkg::PH_EXT64;
					end else begin
						fbl_d     = {25'd0, len7};
						len_known = 1'b1;
					end
				end
				wfr_pkg::PH_EXT16, wfr_pkg::PH_EXT64: begin
					// only the low 32 bits of a 64-bit length survive the shift
					fbl_d = {fbl_q[23:0], b};
					if (hbc_q == ((phase_q == wfr_pkg::PH_EXT16) ? 3'd1 : 3'd7)) begin
						len_known = 1'b1;
					end else begin
						hbc_d = hbc_q + 3'd1;
					end
				end
				wfr_pkg::PH_MASK: begin
					key_d = {key_q[23:0], b};
					if (hbc_q == 3'd3) begin
						pay_begin = 1'b1;
					end else begin
						hbc_d = hbc_q + 3'd1;
					end
				end
				wfr_pkg::PH_PAYLOAD: begin
					mpos_d = mpos_q + 2'd1;
					if (space_q != '0) begin
						stored  = 1'b1;
						space_d = space_q - CW'(1);
						sc_d    = sc_q + CW'(1);
					end
					fbl_d = fbl_q - 32'd1;
					if (fbl_q == 32'd1) begin
						frame_end = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end

		// Length complete: fetch the mask key or go to the payload
		if (len_known) begin
			if (mask_d) begin
				hbc_d   = '0;
				key_d   = '0;
				phase_d = wfr_pkg::PH_MASK;
			end else begin
				pay_begin = 1'b1;
			end
		end

		// Payload start; an empty frame ends right here
		if (pay_begin) begin
			mpos_d = '0;
			if (fbl_d == 32'd0) begin
				frame_end = 1'b1;
			end else begin
				phase_d = wfr_pkg::PH_PAYLOAD;
			end
		end

		// Frame consumed: message ends on a final frame
		if (frame_end) begin
			if (final_d) begin
				phase_d = wfr_pkg::PH_DONE;
				done    = 1'b1;
			end else begin
				phase_d = wfr_pkg::PH_HDR0;
			end
		end
	end

	// Result for this item
	assign res_valid          = stored | done;
	assign res.byte_valid     = stored;
	assign res.out_byte       = stored ? val : 8'd0;
	assign res.out_index      = stored ? sc_old32[15:0] : 16'd0;
	assign res.message_done   = done;
	assign res.message_length = done ? sc_new32[15:0] : 16'd0;
	assign res.frame_opcode   = opc_q;

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= wfr_pkg::PH_IDLE;
			final_q <= 1'b0;
			mask_q  <= 1'b0;
			hbc_q   <= '0;
			fbl_q   <= '0;
			space_q <= '0;
			sc_q    <= '0;
			key_q   <= '0;
			mpos_q  <= '0;
			opc_q   <= '0;
		end else if (en) begin
			phase_q <= phase_d;
			final_q <= final_d;
			mask_q  <= mask_d;
			hbc_q   <= hbc_d;
			fbl_q   <= fbl_d;
			space_q <= space_d;
			sc_q    <= sc_d;
			key_q   <= key_d;
			mpos_q  <= mpos_d;
			opc_q   <= opc_d;
		end
	end

endmodule

[src/websocket_frame_receiver.sv]
`timescale 1ns / 1ps

// Channel   Dir  tdata (low bit up)                                tuser       tlast
// s_axis    in   capacity[15:0], rx_byte[23:16]                    kind        -
// m_axis    out  out_byte[7:0], out_index[23:8],                   byte_valid  message_done
//                message_length[39:24], frame_opcode[43:40]
//
// One item per cycle sustained while the output side does not stall; a result is
// loaded into the output register from the item in the input register, then held until taken.
// The parser state advances once per item in a single pass of logic.
// While the output register holds an untaken result, the input register
// holds its item and s_axis_tready drops once it is full.
// arst_n clears both registers' valid flags and the parser to idle.
module websocket_frame_receiver #(
	parameter int CAPACITY_BITS = wfr_pkg::CAPACITY_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // capacity[15:0], rx_byte[23:16]
	input  logic        s_axis_tuser,  // kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // out_byte, out_index, message_length, frame_opcode
	output logic        m_axis_tuser,  // byte_valid
	output logic        m_axis_tlast   // message_done
);

	logic             v_s1;
	wfr_pkg::item_t   item_s1;
	logic             v_s2;
	wfr_pkg::result_t res_s2;
	logic             adv;
	logic             res_valid;
	wfr_pkg::result_t res;

	// Item in stage 1 moves on when the output register is free or drains
	assign adv           = v_s1 & (~v_s2 | m_axis_tready);
	assign s_axis_tready = ~v_s1 | adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.kind     <= s_axis_tuser;
			item_s1.capacity <= s_axis_tdata[15:0];
			item_s1.rx_byte  <= s_axis_tdata[23:16];
		end
	end

	wfr_parser #(
		.CAPACITY_BITS(CAPACITY_BITS)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.item     (item_s1),
		.res_valid(res_valid),
		.res      (res)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv && res_valid) begin
			v_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_valid) begin
			res_s2 <= res;
		end
	end

	assign m_axis_tvalid = v_s2;
	assign m_axis_tuser  = res_s2.byte_valid;
	assign m_axis_tlast  = res_s2.message_done;
	assign m_axis_tdata  = {4'd0, res_s2.frame_opcode, res_s2.message_length,
		res_s2.out_index, res_s2.out_byte};

endmodule

[src/wfr_checker.sv]
`timescale 1ns / 1ps
`include "websocket_frame_receiver_defines.svh"

// Port-level checks on the result stream and on the input side's ready.
module wfr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [47:0] m_axis_tdata,
	input logic        m_axis_tuser,
	input logic        m_axis_tlast
);

	// A stalled result keeps its contents
	`WFR_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

	// Every result carries a byte, the end of the message, or both
	`WFR_ASSERT_NOW(a_nonempty, m_axis_tvalid, m_axis_tuser || m_axis_tlast)

	// No byte: byte and index fields are zero
	`WFR_ASSERT_NOW(a_nobyte_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[23:0] == 24'd0)

	// Not done: length field is zero
	`WFR_ASSERT_NOW(a_nolen_zero, m_axis_tvalid && !m_axis_tlast, m_axis_tdata[39:24] == 16'd0)

	// A draining output side always lets the input side take an item
	`WFR_ASSERT_NOW(a_ready_drain, m_axis_tready, s_axis_tready)

endmodule

bind websocket_frame_receiver wfr_checker u_wfr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser),
	.m_axis_tlast (m_axis_tlast)
);
